@@ hdl/periodic_timer_table_defines.svh @@
// ----------------------------------------------------------------------------
// Periodic timer table: assertion macros
// Shared property wrappers for the block's checker. Clocked on clock,
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication.
`define PTT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table package
// Request and result codes, slot record and the head unit's interface types.
// ----------------------------------------------------------------------------
package ptt_pkg;

   // Request modes
   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_SET  = 2'd1;
   localparam logic [1:0] MODE_KILL = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_EXPIRY = 2'd0;
   localparam logic [1:0] KIND_SET    = 2'd1;
   localparam logic [1:0] KIND_KILL   = 2'd2;

   // floor(x / 10) = (x * 0xCCCCCCCD) >> 35 for every 32-bit x
   localparam logic [31:0] DIV_TICK_MAGIC = 32'hCCCC_CCCD;
   localparam int          DIV_TICK_SHIFT = 35;

   // Most expiry results reported per tick, and the width of their counter
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic        used;
      logic [31:0] owner;
      logic [31:0] code;
      logic [31:0] remaining;
      logic [31:0] reload;
   } slot_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        found;
      logic [31:0] owner;
      logic [31:0] code;
      logic [31:0] ticks;
   } head_ctrl_type;

   typedef struct packed {
      slot_type nxt;
      logic     hit;
      logic     expire;
   } head_res_type;

endpackage

@@ hdl/ptt_cell.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table: ring cell
// Holds one timer slot and passes it to the next cell on every shift.
// ----------------------------------------------------------------------------
module ptt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_i,
   input  ptt_pkg::slot_type d_i,
   output ptt_pkg::slot_type q_o
);

   logic        used_ff;
   logic [31:0] owner_ff;
   logic [31:0] code_ff;
   logic [31:0] remaining_ff;
   logic [31:0] reload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (shift_i) begin
         used_ff <= d_i.used;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_i) begin
         owner_ff     <= d_i.owner;
         code_ff      <= d_i.code;
         remaining_ff <= d_i.remaining;
         reload_ff    <= d_i.reload;
      end
   end

   assign q_o = '{used: used_ff, owner: owner_ff, code: code_ff,
                  remaining: remaining_ff, reload: reload_ff};

endmodule

@@ hdl/ptt_head.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table: head unit
// Updates the slot leaving the end of the ring for tick, set or kill.
// ----------------------------------------------------------------------------
module ptt_head (
   input  ptt_pkg::slot_type      slot_i,
   input  ptt_pkg::head_ctrl_type ctrl_i,
   output ptt_pkg::head_res_type  res_o
);

   logic [31:0] rem_dec;

   assign rem_dec = slot_i.remaining - 32'd1;

   always_comb begin
      res_o.nxt    = slot_i;
      res_o.hit    = 1'b0;
      res_o.expire = 1'b0;
      case (ctrl_i.mode)
         ptt_pkg::MODE_TICK: begin
            if (slot_i.used) begin
               // reload on reaching zero
               if (rem_dec == 32'd0) begin
                  res_o.nxt.remaining = slot_i.reload;
                  res_o.expire        = 1'b1;
               end else begin
                  res_o.nxt.remaining = rem_dec;
               end
            end
         end
         ptt_pkg::MODE_SET: begin
            // claim the first free slot
            if (!ctrl_i.found && !slot_i.used) begin
               res_o.nxt.used      = 1'b1;
               res_o.nxt.owner     = ctrl_i.owner;
               res_o.nxt.code      = ctrl_i.code;
               res_o.nxt.remaining = ctrl_i.ticks;
               res_o.nxt.reload    = ctrl_i.ticks;
               res_o.hit           = 1'b1;
            end
         end
         ptt_pkg::MODE_KILL: begin
            // drop the first matching slot
            if (!ctrl_i.found && slot_i.used && slot_i.owner == ctrl_i.owner &&
                slot_i.code == ctrl_i.code) begin
               res_o.nxt.used = 1'b0;
               res_o.hit      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

@@ hdl/periodic_timer_table.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table
// Table of periodic timers kept in a rotating ring of slot cells.
// ----------------------------------------------------------------------------
// The TIMER_SLOTS slots sit in a ring of cells that shifts by one position per
// cycle during a request; a single head unit at the end of the ring updates
// whichever slot passes it. Every tick, set or kill request therefore takes
// one full revolution of the ring, then a done step that hands over the final
// result, if any; ready stays low from acceptance until the table is back in
// idle, so a new request is only taken once the last one is through. The
// revolution pauses for as long as an expiry has to go out while the result
// register is still occupied, and the final result waits the same way. A
// request with the unused mode 3 is taken and dropped. Set converts period_ms
// to ticks as period_ms / 10 by a reciprocal multiply at acceptance; a zero
// tick count wraps, expiring after 2^32 ticks. Expiries leave in slot order,
// one held back so the final one can carry last; at most 16 are reported per
// tick, later expiring slots still reload. Set and kill give one status
// result. The result register lets the next request in while a result waits.
// ----------------------------------------------------------------------------
module periodic_timer_table #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_owner_handle,
   input  logic [31:0] req_event_code,
   input  logic [31:0] req_period_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_expired_owner,
   output logic [31:0] rsp_expired_event,
   output logic        rsp_ok,
   output logic        rsp_last
);

   localparam int POS_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [POS_W-1:0] POS_END = POS_W'(TIMER_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] owner_ff, owner_in;
   logic [31:0] code_ff, code_in;
   logic [31:0] ticks_ff, ticks_in;
   logic        found_ff, found_in;

   // held-back expiry, so the final one of a tick can be marked last
   logic        pend_valid_ff, pend_valid_in;
   logic [31:0] pend_owner_ff, pend_owner_in;
   logic [31:0] pend_code_ff, pend_code_in;
   logic [ptt_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_owner_ff, rsp_owner_in;
   logic [31:0] rsp_code_ff, rsp_code_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        shift;
   logic        out_free;
   logic        report;
   logic [63:0] div_prod;

   ptt_pkg::slot_type      cell_d [TIMER_SLOTS];
   ptt_pkg::slot_type      cell_q [TIMER_SLOTS];
   ptt_pkg::head_ctrl_type head_ctrl;
   ptt_pkg::head_res_type  head_res;

   // ---------------------------------------------------------------- ring
   // Head output feeds the first cell; each cell feeds the next.
   for (genvar k = 0; k < TIMER_SLOTS; k++) begin : g_ring
      if (k == 0) begin : g_first
         assign cell_d[k] = head_res.nxt;
      end else begin : g_rest
         assign cell_d[k] = cell_q[k-1];
      end
      ptt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift_i (shift),
         .d_i     (cell_d[k]),
         .q_o     (cell_q[k])
      );
   end

   assign head_ctrl = '{mode: mode_ff, found: found_ff, owner: owner_ff,
                        code: code_ff, ticks: ticks_ff};

   ptt_head u_head (
      .slot_i (cell_q[TIMER_SLOTS-1]),
      .ctrl_i (head_ctrl),
      .res_o  (head_res)
   );

   // period_ms / 10 by reciprocal multiply
   assign div_prod = 64'(req_period_ms) * 64'(ptt_pkg::DIV_TICK_MAGIC);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign report    = head_res.expire && (cnt_ff < ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS));
   assign req_ready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------- control
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      mode_in       = mode_ff;
      owner_in      = owner_ff;
      code_in       = code_ff;
      ticks_in      = ticks_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_owner_in = pend_owner_ff;
      pend_code_in  = pend_code_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_last_in   = rsp_last_ff;
      shift         = 1'b0;

      // drop a result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_mode;
               owner_in      = req_owner_handle;
               code_in       = req_event_code;
               ticks_in      = 32'(div_prod[63:ptt_pkg::DIV_TICK_SHIFT]);
               found_in      = 1'b0;
               pend_valid_in = 1'b0;
               cnt_in        = '0;
               pos_in        = '0;
               // mode 3 is ignored
               if (req_mode == ptt_pkg::MODE_TICK || req_mode == ptt_pkg::MODE_SET ||
                   req_mode == ptt_pkg::MODE_KILL) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // hold the ring while a held expiry cannot move to the output
            if (!(report && pend_valid_ff && !out_free)) begin
               shift = 1'b1;
               if (head_res.hit) begin
                  found_in = 1'b1;
               end
               if (report) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ptt_pkg::KIND_EXPIRY;
                     rsp_owner_in = pend_owner_ff;
                     rsp_code_in  = pend_code_ff;
                     rsp_ok_in    = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_owner_in = cell_q[TIMER_SLOTS-1].owner;
                  pend_code_in  = cell_q[TIMER_SLOTS-1].code;
                  cnt_in        = cnt_ff + ptt_pkg::CNT_W'(1);
               end
               if (pos_ff == POS_END) begin
                  state_in = ST_DONE;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (mode_ff == ptt_pkg::MODE_TICK && !pend_valid_ff) begin
               // tick without expiry: no result
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (mode_ff == ptt_pkg::MODE_TICK) begin
                  rsp_kind_in   = ptt_pkg::KIND_EXPIRY;
                  rsp_owner_in  = pend_owner_ff;
                  rsp_code_in   = pend_code_ff;
                  rsp_ok_in     = 1'b0;
                  pend_valid_in = 1'b0;
               end else begin
                  rsp_kind_in  = (mode_ff == ptt_pkg::MODE_SET) ? ptt_pkg::KIND_SET
                                                               : ptt_pkg::KIND_KILL;
                  rsp_owner_in = '0;
                  rsp_code_in  = '0;
                  rsp_ok_in    = found_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      owner_ff      <= owner_in;
      code_ff       <= code_in;
      ticks_ff      <= ticks_in;
      pend_owner_ff <= pend_owner_in;
      pend_code_ff  <= pend_code_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_expired_owner = rsp_owner_ff;
   assign rsp_expired_event = rsp_code_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

@@ hdl/ptt_checker.sv @@
// ----------------------------------------------------------------------------
// Periodic timer table: port checker
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
`include "periodic_timer_table_defines.svh"

module ptt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_expired_owner,
   input logic [31:0] rsp_expired_event,
   input logic        rsp_ok,
   input logic        rsp_last
);

   logic        rsp_stall;
   logic [67:0] rsp_bits;
   logic        rsp_status;
   logic        status_zero;
   logic        rsp_expiry;
   logic        req_scan;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_bits    = {rsp_kind, rsp_expired_owner, rsp_expired_event, rsp_ok, rsp_last};
   assign rsp_status  = rsp_valid && rsp_kind != ptt_pkg::KIND_EXPIRY;
   assign status_zero = rsp_expired_owner == 32'd0 && rsp_expired_event == 32'd0;
   assign rsp_expiry  = rsp_valid && rsp_kind == ptt_pkg::KIND_EXPIRY;
   assign req_scan    = req_valid && req_ready &&
                        (req_mode == ptt_pkg::MODE_SET || req_mode == ptt_pkg::MODE_KILL ||
                         req_mode == ptt_pkg::MODE_TICK);

   `PTT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_bits), "stalled result moved")

   `PTT_ASSERT_NOW(a_status_last, rsp_status, rsp_last && status_zero, "bad status result")

   `PTT_ASSERT_NOW(a_expiry_ok, rsp_expiry, !rsp_ok, "expiry result with ok set")

   `PTT_ASSERT_NEXT(a_busy_after_req, req_scan, !req_ready, "ready during slot pass")

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Sends tick, set and kill requests into the timer table. A shadow copy of
// the table, updated as each request is accepted, works out the expiry
// and status results. The results that come back are checked field by
// field, in order, against those expectations.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          SLOTS           = 16;
   localparam logic [31:0] MS_PER_TICK     = 32'd10;
   localparam logic [1:0]  MODE_UNUSED     = 2'd3;
   localparam int          RANDOM_REQUESTS = 95;
   // Allow for a full request and for stalls on both sides.
   localparam int          STALL_LIMIT     = 2000;
   localparam int          DRAIN_CYCLES    = 2 * SLOTS + 8;
   localparam int          QUIET_TAIL      = 25;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] owner;
      logic [31:0] code;
      logic [31:0] period;
   } timer_request_type;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] owner;
      logic [31:0] code;
      logic        ok;
      logic        last;
   } timer_result_type;

   typedef struct {
      logic [31:0] owner;
      logic [31:0] code;
   } timer_pair_type;

   // Drive every input to a known value from time zero.
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode         = ptt_pkg::MODE_TICK;
   logic [31:0] req_owner_handle = '0;
   logic [31:0] req_event_code   = '0;
   logic [31:0] req_period_ms    = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_expired_owner;
   logic [31:0] rsp_expired_event;
   logic        rsp_ok;
   logic        rsp_last;

   int errors = 0;

   periodic_timer_table #(
      .TIMER_SLOTS(SLOTS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_owner_handle (req_owner_handle),
      .req_event_code   (req_event_code),
      .req_period_ms    (req_period_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_expired_owner(rsp_expired_owner),
      .rsp_expired_event(rsp_expired_event),
      .rsp_ok           (rsp_ok),
      .rsp_last         (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Shadow timer table. It starts empty, as after reset; the owner, code and
   // count entries of a slot are only looked at while the slot is active.
   // --------------------------------------------------------------------------
   bit          shadow_active [SLOTS];
   logic [31:0] shadow_owner  [SLOTS];
   logic [31:0] shadow_code   [SLOTS];
   logic [31:0] shadow_left   [SLOTS];
   logic [31:0] shadow_period [SLOTS];

   timer_request_type timer_requests[$];     // requests still to be sent
   timer_result_type  timer_results_due[$];  // results owed by the table, oldest first
   timer_pair_type    armed_pairs[$];        // owner/code pairs worth killing later

   // Advance the shadow table by one request and queue the results it causes.
   function automatic void apply_timer_request(input timer_request_type rq);
      timer_result_type burst[$];
      timer_result_type res;
      bit               hit;
      hit = 1'b0;
      res = '{kind: ptt_pkg::KIND_EXPIRY, owner: '0, code: '0, ok: 1'b0, last: 1'b0};
      case (rq.mode)
         ptt_pkg::MODE_TICK: begin
            // Decrement in slot order; a zero count wraps, so a zero period
            // only comes round after 2^32 ticks.
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_active[i]) begin
                  shadow_left[i] = shadow_left[i] - 32'd1;
                  if (shadow_left[i] == 32'd0) begin
                     shadow_left[i] = shadow_period[i];
                     if (burst.size() < ptt_pkg::MAX_RESULTS) begin
                        res.owner = shadow_owner[i];
                        res.code  = shadow_code[i];
                        burst.push_back(res);
                     end
                  end
               end
            end
         end
         ptt_pkg::MODE_SET: begin
            // Take the lowest free slot; duplicates are allowed.
            for (int i = 0; i < SLOTS; i++) begin
               if (!hit && !shadow_active[i]) begin
                  hit              = 1'b1;
                  shadow_active[i] = 1'b1;
                  shadow_owner[i]  = rq.owner;
                  shadow_code[i]   = rq.code;
                  shadow_left[i]   = rq.period / MS_PER_TICK;
                  shadow_period[i] = rq.period / MS_PER_TICK;
               end
            end
            res.kind = ptt_pkg::KIND_SET;
            res.ok   = hit;
            burst.push_back(res);
         end
         ptt_pkg::MODE_KILL: begin
            // Free only the lowest matching slot.
            for (int i = 0; i < SLOTS; i++) begin
               if (!hit && shadow_active[i] && shadow_owner[i] == rq.owner
                   && shadow_code[i] == rq.code) begin
                  hit              = 1'b1;
                  shadow_active[i] = 1'b0;
               end
            end
            res.kind = ptt_pkg::KIND_KILL;
            res.ok   = hit;
            burst.push_back(res);
         end
         default: ;  // unused mode: no change, no result
      endcase
      if (burst.size() > 0)
         burst[burst.size() - 1].last = 1'b1;
      foreach (burst[k])
         timer_results_due.push_back(burst[k]);
   endfunction

   // Idling pauses during some stretches and for the whole tail of the run.
   function automatic bit quiet_phase();
      return timer_requests.size() < QUIET_TAIL || (timer_requests.size() % 50) < 12;
   endfunction

   // --------------------------------------------------------------------------
   // Request driver: hold valid and payload until accepted, idle in bursts.
   // --------------------------------------------------------------------------
   int                send_gap = 0;
   timer_request_type next_request;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         // Update the shadow table the moment the table takes the request.
         if (req_valid && req_ready)
            apply_timer_request('{mode: req_mode, owner: req_owner_handle,
                                  code: req_event_code, period: req_period_ms});
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (timer_requests.size() != 0 && !quiet_phase()
                         && $urandom_range(0, 3) == 0) begin
               // Start an idle burst.
               send_gap = $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (timer_requests.size() != 0) begin
               next_request = timer_requests.pop_front();
               req_valid        <= 1'b1;
               req_mode         <= next_request.mode;
               req_owner_handle <= next_request.owner;
               req_event_code   <= next_request.code;
               req_period_ms    <= next_request.period;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Result monitor: compare each accepted result with the oldest one owed,
   // and stall the result channel in bursts.
   // --------------------------------------------------------------------------
   int               hold_gap = 0;
   timer_result_type owed;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (timer_results_due.size() == 0) begin
               $error("result with nothing owed: kind %0d owner %h event %h ok %b last %b",
                      rsp_kind, rsp_expired_owner, rsp_expired_event, rsp_ok, rsp_last);
               errors++;
            end else begin
               owed = timer_results_due.pop_front();
               if (rsp_kind !== owed.kind) begin
                  $error("kind: expected %0d, got %0d", owed.kind, rsp_kind);
                  errors++;
               end
               if (rsp_expired_owner !== owed.owner) begin
                  $error("expired_owner: expected %h, got %h", owed.owner, rsp_expired_owner);
                  errors++;
               end
               if (rsp_expired_event !== owed.code) begin
                  $error("expired_event: expected %h, got %h", owed.code, rsp_expired_event);
                  errors++;
               end
               if (rsp_ok !== owed.ok) begin
                  $error("ok: expected %b, got %b", owed.ok, rsp_ok);
                  errors++;
               end
               if (rsp_last !== owed.last) begin
                  $error("last: expected %b, got %b", owed.last, rsp_last);
                  errors++;
               end
            end
         end
         if (hold_gap > 0) begin
            hold_gap = hold_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet_phase() && $urandom_range(0, 3) == 0) begin
            hold_gap = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves on either channel for too long.
   // --------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus and end of run
   // --------------------------------------------------------------------------
   task automatic queue_request(input logic [1:0] mode, input logic [31:0] owner,
                                input logic [31:0] code, input logic [31:0] period);
      timer_requests.push_back('{mode: mode, owner: owner, code: code, period: period});
      if (mode == ptt_pkg::MODE_SET)
         armed_pairs.push_back('{owner: owner, code: code});
   endtask

   // Mostly a handful of handles so kills and duplicates collide.
   function automatic logic [31:0] pick_handle();
      return ($urandom_range(0, 4) != 0) ? 32'($urandom_range(1, 4)) : 32'($urandom);
   endfunction

   int             counted;
   int             pick;
   int             idx;
   logic [31:0]    period;
   timer_pair_type victim;

   initial begin
      // Directed part: empty table, unused mode, extremes of every field,
      // zero and sub-tick periods, a full table, hits, misses, a duplicate.
      queue_request(ptt_pkg::MODE_TICK, '0, '0, '0);            // tick on an empty table
      queue_request(MODE_UNUSED, '1, '1, '1);                   // dropped
      queue_request(ptt_pkg::MODE_KILL, '0, '0, '0);            // kill with nothing set
      queue_request(ptt_pkg::MODE_SET, '0, '0, '0);             // zero period wraps
      queue_request(ptt_pkg::MODE_SET, '1, '1, 32'd9);          // under one tick
      queue_request(ptt_pkg::MODE_SET, 32'hA5A5_5A5A, 32'h5A5A_A5A5, '1); // longest period
      for (int i = 3; i < SLOTS; i++)
         queue_request(ptt_pkg::MODE_SET, 32'h100 + i, i,
                       (i % 3 == 0) ? 32'd25 : 32'd10 + i);
      queue_request(ptt_pkg::MODE_SET, 32'hDEAD_0001, 32'h1, 32'd10); // table full
      queue_request(ptt_pkg::MODE_TICK, '1, '1, '1);            // burst of expiries
      queue_request(ptt_pkg::MODE_TICK, '0, '0, '0);            // two-tick slots too
      queue_request(ptt_pkg::MODE_KILL, '1, '1, '0);            // hit
      queue_request(ptt_pkg::MODE_KILL, '1, '1, '0);            // same pair again: miss
      queue_request(ptt_pkg::MODE_SET, 32'h103, 32'd3, 32'd10); // duplicate of a live timer
      queue_request(ptt_pkg::MODE_KILL, 32'h103, 32'd3, '0);    // frees the lower copy
      queue_request(ptt_pkg::MODE_TICK, '0, '0, '0);

      // Random part: mostly ticks, sets and kills of pairs set earlier, with some
      // misses and the odd unused mode thrown in.
      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            queue_request(ptt_pkg::MODE_TICK, $urandom, $urandom, $urandom);
            counted++;
         end else if (pick < 65) begin
            idx = $urandom_range(0, 19);
            if (idx < 14)
               period = $urandom_range(10, 69);
            else if (idx < 17)
               period = $urandom_range(0, 9);
            else
               period = $urandom;
            queue_request(ptt_pkg::MODE_SET, pick_handle(), pick_handle(), period);
            counted++;
         end else if (pick < 92) begin
            if (armed_pairs.size() != 0 && $urandom_range(0, 4) != 0) begin
               idx    = $urandom_range(0, armed_pairs.size() - 1);
               victim = armed_pairs[idx];
               armed_pairs.delete(idx);
               queue_request(ptt_pkg::MODE_KILL, victim.owner, victim.code, $urandom);
            end else begin
               queue_request(ptt_pkg::MODE_KILL, pick_handle(), pick_handle(), $urandom);
            end
            counted++;
         end else begin
            queue_request(MODE_UNUSED, $urandom, $urandom, $urandom);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request to go in, then for every owed result.
      @(negedge clock);
      while (timer_requests.size() != 0 || req_valid)
         @(negedge clock);
      while (timer_results_due.size() != 0)
         @(negedge clock);
      // Let any stray result show up.
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ periodic_timer_table.f @@
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_cell.sv
hdl/ptt_head.sv
hdl/periodic_timer_table.sv
hdl/ptt_checker.sv
tb/tb_top.sv
